>>> src/rrtp_pkg.sv
// shared types, constants and codes for the round-robin task picker
`timescale 1ns / 1ps

package rrtp_pkg;

    // table geometry
    localparam int SLOT_COUNT = 1024;
    localparam int LANES      = 16;
    localparam int LANE_W     = $clog2(LANES);
    localparam int ROWS       = (SLOT_COUNT + LANES - 1) / LANES;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int STATUS_W   = 3;
    localparam int ROW_DATA_W = LANES * STATUS_W;
    localparam int SLOT_W     = 10;

    typedef logic [ROW_W-1:0]      row_t;
    typedef logic [LANE_W-1:0]     lane_t;
    typedef logic [STATUS_W-1:0]   status_t;
    typedef logic [ROW_DATA_W-1:0] row_data_t;
    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [1:0]            decision_t;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SCHED = 1'b1;

    // slot status codes
    localparam status_t ST_FREE     = 3'd0;
    localparam status_t ST_DYING    = 3'd1;
    localparam status_t ST_RUNNABLE = 3'd2;
    localparam status_t ST_RUNNING  = 3'd3;

    // decision codes
    localparam decision_t DEC_RUN  = 2'd0;
    localparam decision_t DEC_KEEP = 2'd1;
    localparam decision_t DEC_HALT = 2'd2;
    localparam decision_t DEC_NONE = 2'd3;

    // request word
    typedef struct packed {
        logic    operation;
        slot_t   slot_index;
        status_t new_status;
        logic    has_current;
        slot_t   current_slot;
    } req_word_t;

    // response word
    typedef struct packed {
        decision_t decision;
        slot_t     picked_slot;
    } rsp_word_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic wr_read;
        logic wr_commit;
        logic scan_read;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic req_sched;
        logic last_row;
        logic out_free;
    } dp_stat_t;

endpackage

>>> src/rrtp_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module rrtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/rrtp_ctrl.sv
// sequencing state machine for status writes and table scans
`timescale 1ns / 1ps

module rrtp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  rrtp_pkg::dp_stat_t  stat,
    output rrtp_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR_READ,
        S_WR_WRITE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   accept;

    assign req_stall = busy_reg;
    assign accept    = req_valid && !busy_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    state_next  = stat.req_sched ? S_SCAN : S_WR_READ;
                end
            end
            S_WR_READ:
            begin
                cmd.wr_read = 1'b1;
                state_next  = S_WR_WRITE;
            end
            S_WR_WRITE:
            begin
                cmd.wr_commit = 1'b1;
                state_next    = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_read = 1'b1;
                if (stat.last_row)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

endmodule

>>> src/rrtp_datapath.sv
// status table, row scan accumulators and response register
`timescale 1ns / 1ps

module rrtp_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rrtp_pkg::req_word_t  req,
    input  rrtp_pkg::ctrl_cmd_t  cmd,
    output rrtp_pkg::dp_stat_t   stat,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rrtp_pkg::rsp_word_t  rsp
);

    // captured request
    rrtp_pkg::row_t    idx_row_reg;
    rrtp_pkg::lane_t   idx_lane_reg;
    rrtp_pkg::status_t st_reg;
    logic              wr_ok_reg;
    rrtp_pkg::row_t    start_row_reg;
    rrtp_pkg::lane_t   start_lane_reg;
    logic              has_cur_reg;

    // scan control
    rrtp_pkg::row_t    scan_row_reg;
    rrtp_pkg::row_t    rd_row_reg;
    logic              proc_valid_reg;
    logic [rrtp_pkg::ROWS-1:0] row_valid_reg;

    // scan accumulators
    logic              found_after_reg;
    rrtp_pkg::slot_t   after_slot_reg;
    logic              found_any_reg;
    rrtp_pkg::slot_t   any_slot_reg;
    logic              live_reg;
    logic              cur_running_reg;

    // response register
    logic                rsp_valid_reg;
    rrtp_pkg::rsp_word_t rsp_reg;
    rrtp_pkg::rsp_word_t rsp_next;

    // memory signals
    rrtp_pkg::row_t    raddr;
    rrtp_pkg::row_data_t ram_q;
    rrtp_pkg::row_data_t rd_data;
    rrtp_pkg::row_data_t wr_data;
    logic              ram_we;

    // lane evaluation
    logic [rrtp_pkg::LANES-1:0] runnable_mask;
    logic [rrtp_pkg::LANES-1:0] after_mask;
    logic [rrtp_pkg::LANES-1:0] live_mask;
    logic              after_hit;
    rrtp_pkg::lane_t   after_lane;
    logic              any_hit;
    rrtp_pkg::lane_t   any_lane;
    logic              cur_run;
    logic              start_valid;
    rrtp_pkg::slot_t   start_slot;

    // status to controller
    assign stat.req_sched = (req.operation == rrtp_pkg::OP_SCHED);
    assign stat.last_row  = (scan_row_reg == rrtp_pkg::row_t'(rrtp_pkg::ROWS - 1));
    assign stat.out_free  = !rsp_valid_reg || !rsp_stall;

    // start slot of the circular search
    assign start_valid = req.has_current &&
                         (32'(req.current_slot) < 32'(rrtp_pkg::SLOT_COUNT));
    assign start_slot  = start_valid ? req.current_slot : '0;

    // capture the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_row_reg    <= rrtp_pkg::row_t'(req.slot_index >> rrtp_pkg::LANE_W);
            idx_lane_reg   <= rrtp_pkg::lane_t'(req.slot_index);
            st_reg         <= req.new_status;
            wr_ok_reg      <= (32'(req.slot_index) < 32'(rrtp_pkg::SLOT_COUNT));
            start_row_reg  <= rrtp_pkg::row_t'(start_slot >> rrtp_pkg::LANE_W);
            start_lane_reg <= rrtp_pkg::lane_t'(start_slot);
            has_cur_reg    <= start_valid;
        end
    end

    // status table, one row of sixteen slots per word
    assign raddr  = cmd.wr_read ? idx_row_reg : scan_row_reg;
    assign ram_we = cmd.wr_commit && wr_ok_reg;

    rrtp_ram #(
        .WIDTH (rrtp_pkg::ROW_DATA_W),
        .DEPTH (rrtp_pkg::ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_row_reg),
        .wdata (wr_data),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // rows never written read as all free
    assign rd_data = row_valid_reg[rd_row_reg] ? ram_q : '0;

    // merge the new status into the row
    always_comb
    begin
        wr_data = rd_data;
        for (int l = 0; l < rrtp_pkg::LANES; l++)
        begin
            if (idx_lane_reg == rrtp_pkg::lane_t'(l))
            begin
                wr_data[l*rrtp_pkg::STATUS_W +: rrtp_pkg::STATUS_W] = st_reg;
            end
        end
    end

    // scan control and row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg  <= '0;
            scan_row_reg   <= '0;
            proc_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            proc_valid_reg <= cmd.scan_read;
            if (cmd.capture)
            begin
                scan_row_reg <= '0;
            end
            else if (cmd.scan_read)
            begin
                scan_row_reg <= scan_row_reg + 1'b1;
            end
            if (ram_we)
            begin
                row_valid_reg[idx_row_reg] <= 1'b1;
            end
            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // read row address follows the read data
    always_ff @(posedge clk)
    begin
        rd_row_reg <= raddr;
    end

    // per-lane classification
    always_comb
    begin
        for (int l = 0; l < rrtp_pkg::LANES; l++)
        begin
            runnable_mask[l] = (rd_data[l*rrtp_pkg::STATUS_W +: rrtp_pkg::STATUS_W]
                                == rrtp_pkg::ST_RUNNABLE);
            live_mask[l]     = runnable_mask[l] ||
                               (rd_data[l*rrtp_pkg::STATUS_W +: rrtp_pkg::STATUS_W]
                                == rrtp_pkg::ST_RUNNING) ||
                               (rd_data[l*rrtp_pkg::STATUS_W +: rrtp_pkg::STATUS_W]
                                == rrtp_pkg::ST_DYING);
            after_mask[l]    = runnable_mask[l] &&
                               ((rd_row_reg > start_row_reg) ||
                                ((rd_row_reg == start_row_reg) &&
                                 (rrtp_pkg::lane_t'(l) > start_lane_reg)));
        end
    end

    // lowest-lane priority encoders
    always_comb
    begin
        after_hit  = 1'b0;
        after_lane = '0;
        any_hit    = 1'b0;
        any_lane   = '0;
        for (int l = rrtp_pkg::LANES - 1; l >= 0; l--)
        begin
            if (after_mask[l])
            begin
                after_hit  = 1'b1;
                after_lane = rrtp_pkg::lane_t'(l);
            end
            if (runnable_mask[l])
            begin
                any_hit  = 1'b1;
                any_lane = rrtp_pkg::lane_t'(l);
            end
        end
    end

    // current slot still running
    assign cur_run = has_cur_reg && (rd_row_reg == start_row_reg) &&
                     (rd_data[start_lane_reg*rrtp_pkg::STATUS_W +: rrtp_pkg::STATUS_W]
                      == rrtp_pkg::ST_RUNNING);

    // accumulate over the rows in ascending order
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            found_after_reg <= 1'b0;
            found_any_reg   <= 1'b0;
            live_reg        <= 1'b0;
            cur_running_reg <= 1'b0;
            after_slot_reg  <= '0;
            any_slot_reg    <= '0;
        end
        else if (proc_valid_reg)
        begin
            if (!found_after_reg && after_hit)
            begin
                found_after_reg <= 1'b1;
                after_slot_reg  <= rrtp_pkg::slot_t'({rd_row_reg, after_lane});
            end
            if (!found_any_reg && any_hit)
            begin
                found_any_reg <= 1'b1;
                any_slot_reg  <= rrtp_pkg::slot_t'({rd_row_reg, any_lane});
            end
            live_reg        <= live_reg || (|live_mask);
            cur_running_reg <= cur_running_reg || cur_run;
        end
    end

    // final decision
    always_comb
    begin
        rsp_next = '0;
        if (found_after_reg)
        begin
            rsp_next.decision    = rrtp_pkg::DEC_RUN;
            rsp_next.picked_slot = after_slot_reg;
        end
        else if (found_any_reg)
        begin
            rsp_next.decision    = rrtp_pkg::DEC_RUN;
            rsp_next.picked_slot = any_slot_reg;
        end
        else if (cur_running_reg)
        begin
            rsp_next.decision    = rrtp_pkg::DEC_KEEP;
            rsp_next.picked_slot = rrtp_pkg::slot_t'({start_row_reg, start_lane_reg});
        end
        else if (live_reg)
        begin
            rsp_next.decision = rrtp_pkg::DEC_HALT;
        end
        else
        begin
            rsp_next.decision = rrtp_pkg::DEC_NONE;
        end
    end

    // response word register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> src/round_robin_task_picker.sv
// top level of the round-robin task picker
`timescale 1ns / 1ps

// Round-robin task picker. Keeps a status word for each task slot in a
// memory of sixteen slots per row; rows never written read as free, so the
// table is usable straight after reset with no clearing pass. A status write
// is a read-modify-write of one row, with the request side stalled while
// the row is read and written back. A schedule request reads one row per
// cycle, so its response word is loaded after every row has been read, and
// the next request can be taken after that; the scan length is set by the
// single read port of the status memory. The response sits in its own
// register, so a stalled response does not hold up status writes; a
// following schedule request waits at its end until the response register
// is free. One request is handled at a time.
module round_robin_task_picker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  rrtp_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output rrtp_pkg::rsp_word_t rsp
);

    rrtp_pkg::ctrl_cmd_t cmd;
    rrtp_pkg::dp_stat_t  stat;

    // sequencing
    rrtp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // table and scan datapath
    rrtp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

>>> src/rrtp_checker.sv
// port-level checks for the round-robin task picker
`timescale 1ns / 1ps

module rrtp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input rrtp_pkg::req_word_t req,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input rrtp_pkg::rsp_word_t rsp
);

    // a stalled response word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response word changed");

    // halt and no-live decisions carry a zero slot
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.decision == rrtp_pkg::DEC_HALT ||
                      rsp.decision == rrtp_pkg::DEC_NONE) |-> rsp.picked_slot == '0)
    else $error("non-zero slot on halt or no-live decision");

    // a schedule request keeps the request side busy while it scans
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.operation == rrtp_pkg::OP_SCHED |=> req_stall)
    else $error("request accepted during a scan");

    // a status write never produces a response word
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.operation == rrtp_pkg::OP_WRITE && !rsp_valid
        |=> !rsp_valid)
    else $error("response appeared after a status write");

endmodule

bind round_robin_task_picker rrtp_checker u_rrtp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

>>> tb/sv/round_robin_task_picker_tb.sv
// self-checking testbench for the round-robin task picker
`timescale 1ns / 1ps

module round_robin_task_picker_tb;

    // status codes with no name in the package
    localparam rrtp_pkg::status_t ST_BLOCKED    = 3'd4;
    localparam rrtp_pkg::status_t ST_UNNAMED_LO = 3'd5;
    localparam rrtp_pkg::status_t ST_UNNAMED_HI = 3'd7;

    localparam int ITEM_TARGET  = 1350;
    localparam int DRAIN_CYCLES = 100;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    rrtp_pkg::req_word_t req = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    rrtp_pkg::rsp_word_t rsp;

    // predicted slot table and the decisions still owed by the block
    rrtp_pkg::status_t   slot_table [rrtp_pkg::SLOT_COUNT];
    rrtp_pkg::rsp_word_t pending_decisions [$];

    // slots given a status by the stimulus, so they can be freed again
    rrtp_pkg::slot_t     touched_slots [$];

    int  items_sent = 0;
    int  fail_count = 0;
    int  stall_run  = 0;
    bit  req_idle_on = 1'b0;
    bit  rsp_idle_on = 1'b0;

    round_robin_task_picker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // hard limit on the run
    initial
    begin
        #(20_000_000);
        $display("Test completed with failures");
        $finish;
    end

    // circular search for the next slot to run, current slot checked last
    function automatic rrtp_pkg::rsp_word_t pick_task(input logic has_cur,
                                                      input rrtp_pkg::slot_t cur);
        int                  start;
        int                  j;
        logic                cur_ok;
        rrtp_pkg::rsp_word_t r;
        cur_ok = has_cur && (int'(cur) < rrtp_pkg::SLOT_COUNT);
        start = cur_ok ? int'(cur) : 0;
        for (int n = 1; n <= rrtp_pkg::SLOT_COUNT; n++)
        begin
            j = (start + n) % rrtp_pkg::SLOT_COUNT;
            if (slot_table[j] == rrtp_pkg::ST_RUNNABLE)
            begin
                r.decision = rrtp_pkg::DEC_RUN;
                r.picked_slot = rrtp_pkg::slot_t'(j);
                return r;
            end
        end
        if (cur_ok && slot_table[start] == rrtp_pkg::ST_RUNNING)
        begin
            r.decision = rrtp_pkg::DEC_KEEP;
            r.picked_slot = rrtp_pkg::slot_t'(start);
            return r;
        end
        r.decision = rrtp_pkg::DEC_NONE;
        r.picked_slot = '0;
        for (int n = 0; n < rrtp_pkg::SLOT_COUNT; n++)
        begin
            if (slot_table[n] == rrtp_pkg::ST_RUNNABLE ||
                slot_table[n] == rrtp_pkg::ST_RUNNING ||
                slot_table[n] == rrtp_pkg::ST_DYING)
            begin
                r.decision = rrtp_pkg::DEC_HALT;
            end
        end
        return r;
    endfunction

    task automatic flag_result(input string what, input rrtp_pkg::rsp_word_t want);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: %s: expected decision %0d slot %0d, got decision %0d slot %0d",
                     $realtime, what, want.decision, want.picked_slot,
                     rsp.decision, rsp.picked_slot);
        end
    endtask

    // checks response words, tracks accepted request words, drives response stall
    always @(posedge clk)
    begin
        rrtp_pkg::rsp_word_t want;
        int                  r;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            // response first, so a decision predicted at this edge cannot be consumed
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_decisions.size() == 0)
                begin
                    flag_result("response word with none outstanding", '0);
                end
                else
                begin
                    want = pending_decisions.pop_front();
                    if (rsp.decision !== want.decision || rsp.picked_slot !== want.picked_slot)
                        flag_result("decision mismatch", want);
                end
            end

            // accepted request word updates the prediction
            if (req_valid && !req_stall)
            begin
                if (req.operation == rrtp_pkg::OP_WRITE)
                begin
                    if (int'(req.slot_index) < rrtp_pkg::SLOT_COUNT)
                        slot_table[req.slot_index] = req.new_status;
                end
                else
                begin
                    pending_decisions.push_back(pick_task(req.has_current, req.current_slot));
                end
            end

            // response stall: mostly short, now and then long
            if (stall_run > 0)
            begin
                stall_run--;
                rsp_stall <= 1'b1;
            end
            else if (!rsp_idle_on)
            begin
                rsp_stall <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    rsp_stall <= 1'b0;
                end
                else if (r < 93)
                begin
                    stall_run = $urandom_range(0, 2);
                    rsp_stall <= 1'b1;
                end
                else
                begin
                    stall_run = $urandom_range(8, 40);
                    rsp_stall <= 1'b1;
                end
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (!req_idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // present one request word and hold it until accepted
    task automatic send_word(input rrtp_pkg::req_word_t w);
        int gap;
        req <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
        gap = sender_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // status write; schedule fields carry junk
    task automatic write_status(input rrtp_pkg::slot_t s, input rrtp_pkg::status_t st);
        rrtp_pkg::req_word_t w;
        w.operation = rrtp_pkg::OP_WRITE;
        w.slot_index = s;
        w.new_status = st;
        w.has_current = 1'($urandom_range(0, 1));
        w.current_slot = rrtp_pkg::slot_t'($urandom_range(0, 1023));
        touched_slots.push_back(s);
        send_word(w);
    endtask

    // schedule request; write fields carry junk
    task automatic schedule(input logic has_cur, input rrtp_pkg::slot_t cur);
        rrtp_pkg::req_word_t w;
        w.operation = rrtp_pkg::OP_SCHED;
        w.slot_index = rrtp_pkg::slot_t'($urandom_range(0, 1023));
        w.new_status = rrtp_pkg::status_t'($urandom_range(0, 7));
        w.has_current = has_cur;
        w.current_slot = cur;
        send_word(w);
    endtask

    // sender holds off until every decision has come back
    task automatic drain();
        req_valid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // free every touched slot without recording it again
    task automatic clear_touched();
        rrtp_pkg::req_word_t w;
        while (touched_slots.size() != 0)
        begin
            w.operation = rrtp_pkg::OP_WRITE;
            w.slot_index = touched_slots.pop_front();
            w.new_status = rrtp_pkg::ST_FREE;
            w.has_current = 1'($urandom_range(0, 1));
            w.current_slot = rrtp_pkg::slot_t'($urandom_range(0, 1023));
            send_word(w);
        end
    endtask

    function automatic rrtp_pkg::status_t random_status(input bit no_runnable);
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return no_runnable ? rrtp_pkg::ST_RUNNING : rrtp_pkg::ST_RUNNABLE;
        if (r < 55)
            return rrtp_pkg::ST_RUNNING;
        if (r < 65)
            return rrtp_pkg::ST_DYING;
        if (r < 80)
            return rrtp_pkg::ST_FREE;
        if (r < 90)
            return ST_BLOCKED;
        return rrtp_pkg::status_t'($urandom_range(5, 7));
    endfunction

    // corners: empty table, wrap-around, current checked last, keep, halt, unnamed codes
    task automatic test_directed();
        schedule(1'b0, '0);
        schedule(1'b1, 10'd1023);
        write_status(10'd0, rrtp_pkg::ST_RUNNING);
        schedule(1'b0, 10'd1023);
        schedule(1'b1, 10'd0);
        write_status(10'd1023, rrtp_pkg::ST_RUNNABLE);
        schedule(1'b1, 10'd1023);
        schedule(1'b0, 10'd0);
        write_status(10'd5, rrtp_pkg::ST_RUNNABLE);
        schedule(1'b1, 10'd1023);
        schedule(1'b1, 10'd5);
        write_status(10'd1023, ST_UNNAMED_HI);
        write_status(10'd5, ST_BLOCKED);
        schedule(1'b1, 10'd0);
        write_status(10'd0, rrtp_pkg::ST_DYING);
        schedule(1'b1, 10'd0);
        write_status(10'd0, ST_UNNAMED_LO);
        schedule(1'b0, 10'd0);
        clear_touched();
        schedule(1'b1, 10'd512);
    endtask

    // bursts of writes into a small window of slots, then decisions around it
    task automatic test_window_traffic(input int target);
        int              base;
        int              width;
        int              n_sched;
        int              r;
        bit              no_runnable;
        rrtp_pkg::slot_t cur;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 2) == 0)
                clear_touched();
            no_runnable = ($urandom_range(0, 2) == 0);
            base = $urandom_range(0, 1023);
            width = $urandom_range(1, 12);
            for (int k = 0; k < width; k++)
                write_status(rrtp_pkg::slot_t'((base + k) % rrtp_pkg::SLOT_COUNT),
                             random_status(no_runnable));
            // an occasional stray write anywhere in the table
            if ($urandom_range(0, 4) == 0)
                write_status(rrtp_pkg::slot_t'($urandom_range(0, 1023)),
                             rrtp_pkg::status_t'($urandom_range(0, 7)));
            n_sched = $urandom_range(1, 4);
            for (int k = 0; k < n_sched; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    cur = rrtp_pkg::slot_t'((base + $urandom_range(0, width - 1))
                                            % rrtp_pkg::SLOT_COUNT);
                else if (r < 70)
                    cur = rrtp_pkg::slot_t'($urandom_range(0, 1023));
                else
                    cur = touched_slots[$urandom_range(0, touched_slots.size() - 1)];
                schedule(($urandom_range(0, 99) < 85), cur);
            end
        end
    endtask

    // fully random words: any operation, any field values
    task automatic test_random_words(input int count);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 1) == 0)
                write_status(rrtp_pkg::slot_t'($urandom_range(0, 1023)),
                             rrtp_pkg::status_t'($urandom_range(0, 7)));
            else
                schedule(1'($urandom_range(0, 1)), rrtp_pkg::slot_t'($urandom_range(0, 1023)));
        end
        clear_touched();
    endtask

    // test sequence
    initial
    begin
        for (int n = 0; n < rrtp_pkg::SLOT_COUNT; n++)
            slot_table[n] = rrtp_pkg::ST_FREE;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        drain();

        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
        test_window_traffic(600);

        // a stretch with no idling on either side
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        test_random_words(150);
        test_window_traffic(850);
        drain();

        req_idle_on = 1'b1;
        test_window_traffic(1050);

        req_idle_on = 1'b0;
        rsp_idle_on = 1'b1;
        test_window_traffic(1200);

        req_idle_on = 1'b1;
        test_window_traffic(ITEM_TARGET);

        // wind down
        req_valid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
